// ----- sv/pts_pkg.sv -----
// ----------------------------------------------------------------------------
// pts_pkg
// Shared types and constants for the pixel threshold scan block.
// ----------------------------------------------------------------------------
package pts_pkg;

  // Number of events expected in one readout burst
  localparam int unsigned TRIALS = 20;
  localparam int unsigned CntW   = 5;

  localparam logic [CntW-1:0] TrialsCnt   = CntW'(TRIALS);
  localparam logic [CntW-1:0] MajorityCnt = CntW'(TRIALS / 2);

  // Readout word decoding
  localparam logic [15:0] HdrMask  = 16'h8ffc;
  localparam logic [15:0] HdrMatch = 16'h87f8;

  // DAC limits and start values
  localparam logic [7:0] DacUpLimit   = 8'd253;
  localparam logic [7:0] LevelHigh    = 8'd250;
  localparam logic [7:0] StartDefault = 8'd100;
  localparam logic [7:0] StartLow     = 8'd20;
  localparam logic [7:0] LevelReset   = 8'd9;

  typedef enum logic [1:0] {
    FuncStart = 2'd0,
    FuncWord  = 2'd1,
    FuncEnd   = 2'd2,
    FuncNone  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    KindSetDac  = 2'd0,
    KindFound   = 2'd1,
    KindMissing = 2'd2,
    KindWrong   = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PhIdle  = 2'd0,
    PhFirst = 2'd1,
    PhDown  = 2'd2,
    PhUp    = 2'd3
  } phase_e;

  // Burst summary handed from the parser to the search control
  typedef struct packed {
    logic wrong_hdr;
    logic missing;
    logic fired;
  } burst_t;

endpackage

// ----- sv/pts_parser.sv -----
// ----------------------------------------------------------------------------
// pts_parser
// Parses readout words into events and summarizes a burst at its end.
// ----------------------------------------------------------------------------
module pts_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  pts_pkg::func_e   func_i,
  input  logic [15:0]      word_i,
  output pts_pkg::burst_t  burst_o
);

  logic [pts_pkg::CntW-1:0] event_cnt_q, event_cnt_d;
  logic [pts_pkg::CntW-1:0] fired_cnt_q, fired_cnt_d;
  logic                     in_event_q, in_event_d;
  logic                     has_hit_q, has_hit_d;
  logic                     wrong_q, wrong_d;
  logic [pts_pkg::CntW-1:0] fired_closed;

  // Fired count as it stands once the open event is closed
  assign fired_closed = fired_cnt_q + pts_pkg::CntW'(in_event_q & has_hit_q);

  assign burst_o.wrong_hdr = wrong_q;
  assign burst_o.missing   = (event_cnt_q < pts_pkg::TrialsCnt);
  assign burst_o.fired     = (fired_closed > pts_pkg::MajorityCnt);

  // Next parser state for the current transaction
  always_comb begin
    event_cnt_d = event_cnt_q;
    fired_cnt_d = fired_cnt_q;
    in_event_d  = in_event_q;
    has_hit_d   = has_hit_q;
    wrong_d     = wrong_q;
    case (func_i)
      pts_pkg::FuncStart, pts_pkg::FuncEnd: begin
        event_cnt_d = '0;
        fired_cnt_d = '0;
        in_event_d  = 1'b0;
        has_hit_d   = 1'b0;
        wrong_d     = 1'b0;
      end
      pts_pkg::FuncWord: begin
        if (!wrong_q) begin
          if (in_event_q && !word_i[15]) begin
            has_hit_d = 1'b1;
          end else begin
            // Close the open event
            fired_cnt_d = fired_closed;
            in_event_d  = 1'b0;
            has_hit_d   = 1'b0;
            if (event_cnt_q < pts_pkg::TrialsCnt) begin
              if ((word_i & pts_pkg::HdrMask) != pts_pkg::HdrMatch) begin
                wrong_d = 1'b1;
              end else begin
                event_cnt_d = event_cnt_q + pts_pkg::CntW'(1);
                in_event_d  = 1'b1;
              end
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_cnt_q <= '0;
      fired_cnt_q <= '0;
      in_event_q  <= 1'b0;
      has_hit_q   <= 1'b0;
      wrong_q     <= 1'b0;
    end else if (step_i) begin
      event_cnt_q <= event_cnt_d;
      fired_cnt_q <= fired_cnt_d;
      in_event_q  <= in_event_d;
      has_hit_q   <= has_hit_d;
      wrong_q     <= wrong_d;
    end
  end

endmodule

// ----- sv/pts_search.sv -----
// ----------------------------------------------------------------------------
// pts_search
// Search control: start value, DAC stepping and level reporting.
// ----------------------------------------------------------------------------
module pts_search (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             step_i,
  input  pts_pkg::func_e   func_i,
  input  logic             first_row_i,
  input  pts_pkg::burst_t  burst_i,
  output logic             res_valid_o,
  output pts_pkg::kind_e   res_kind_o,
  output logic [7:0]       res_value_o
);

  pts_pkg::phase_e phase_q, phase_d;
  logic [7:0]      dac_q, dac_d;
  logic [7:0]      level_q, level_d;
  logic            cal_mode_q;
  logic [7:0]      start_val;
  logic [7:0]      found_val;

  // Pick the start value: last level found, else the default or the low start
  always_comb begin
    start_val = level_q;
    if (first_row_i || ((level_q > pts_pkg::LevelHigh) && cal_mode_q)) begin
      start_val = pts_pkg::StartDefault;
    end
    if (start_val == 8'd0) begin
      start_val = pts_pkg::StartLow;
    end
  end

  // Next search state and result
  always_comb begin
    phase_d     = phase_q;
    dac_d       = dac_q;
    level_d     = level_q;
    res_valid_o = 1'b0;
    res_kind_o  = pts_pkg::KindSetDac;
    res_value_o = '0;
    found_val   = dac_q;
    case (func_i)
      pts_pkg::FuncStart: begin
        dac_d       = start_val;
        phase_d     = pts_pkg::PhFirst;
        res_valid_o = 1'b1;
        res_value_o = start_val;
      end
      pts_pkg::FuncEnd: begin
        if (phase_q != pts_pkg::PhIdle) begin
          res_valid_o = 1'b1;
          if (burst_i.wrong_hdr || burst_i.missing) begin
            phase_d    = pts_pkg::PhIdle;
            res_kind_o = burst_i.wrong_hdr ? pts_pkg::KindWrong : pts_pkg::KindMissing;
          end else if (phase_q == pts_pkg::PhFirst) begin
            dac_d       = burst_i.fired ? dac_q - 8'd1 : dac_q + 8'd1;
            phase_d     = burst_i.fired ? pts_pkg::PhDown : pts_pkg::PhUp;
            res_value_o = dac_d;
          end else if (phase_q == pts_pkg::PhDown && burst_i.fired &&
                       dac_q != 8'd0) begin
            dac_d       = dac_q - 8'd1;
            res_value_o = dac_d;
          end else if (phase_q == pts_pkg::PhUp && !burst_i.fired &&
                       dac_q < pts_pkg::DacUpLimit) begin
            dac_d       = dac_q + 8'd1;
            res_value_o = dac_d;
          end else begin
            // Level found: stepping down reports one above the last DAC value
            found_val   = (phase_q == pts_pkg::PhDown) ? dac_q + 8'd1 : dac_q;
            level_d     = found_val;
            phase_d     = pts_pkg::PhIdle;
            res_kind_o  = pts_pkg::KindFound;
            res_value_o = found_val;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pts_pkg::PhIdle;
      dac_q   <= '0;
      level_q <= pts_pkg::LevelReset;
    end else if (step_i) begin
      phase_q <= phase_d;
      dac_q   <= dac_d;
      level_q <= level_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      cal_mode_q <= cfg_wdata_i;
    end
  end

endmodule

// ----- sv/pixel_threshold_scan.sv -----
// ----------------------------------------------------------------------------
// pixel_threshold_scan
// Threshold search control for one pixel on a calibration DAC.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: tuser carries the function (start, readout word,
//   end of burst), tdata carries the first-row flag and the readout word.
//   Output stream m_axis: tuser carries the result kind, tdata the DAC
//   value to set or the level found (zero for error kinds).
//   A start transaction and an end-of-burst transaction during a search give
//   one result each; readout words and unused functions give none.
//   A result passes through the input register, then the result register,
//   before it appears on m_axis.
//   Throughput: one transaction per cycle while m_axis is not stalled with a
//   result held; the parser counters and search state update on each step.
//   The calibration mode register is written through cfg_we_i / cfg_wdata_i;
//   the user must write it only while the block is idle; it does not check.
//   Reset clears the search to idle with a last level of 9 and clears the
//   burst parser and the calibration mode.
//   When m_axis stalls with a result held, the input register keeps its
//   transaction and s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module pixel_threshold_scan (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [0] first_row, [16:1] word, zero fill
  input  logic [1:0]  s_axis_tuser,  // [1:0] func
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] value
  output logic [1:0]  m_axis_tuser   // [1:0] kind
);

  logic            in_valid_q;
  pts_pkg::func_e  in_func_q;
  logic            in_first_row_q;
  logic [15:0]     in_word_q;

  logic            out_valid_q;
  pts_pkg::kind_e  out_kind_q;
  logic [7:0]      out_value_q;

  logic            out_free;
  logic            step;
  pts_pkg::burst_t burst;
  logic            res_valid;
  pts_pkg::kind_e  res_kind;
  logic [7:0]      res_value;

  // Advance the held transaction when the result register can take it
  assign out_free      = !out_valid_q || m_axis_tready;
  assign step          = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || out_free;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func_q      <= pts_pkg::func_e'(s_axis_tuser);
      in_first_row_q <= s_axis_tdata[0];
      in_word_q      <= s_axis_tdata[16:1];
    end
  end

  pts_parser u_parser (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (step),
    .func_i  (in_func_q),
    .word_i  (in_word_q),
    .burst_o (burst)
  );

  pts_search u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .step_i      (step),
    .func_i      (in_func_q),
    .first_row_i (in_first_row_q),
    .burst_i     (burst),
    .res_valid_o (res_valid),
    .res_kind_o  (res_kind),
    .res_value_o (res_value)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_kind_q  <= res_kind;
      out_value_q <= res_value;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_value_q;
  assign m_axis_tuser  = out_kind_q;

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pixel_threshold_scan. A behavioral copy of the
// search control predicts the result of every accepted input transaction;
// results leaving the block are compared field by field in order. Covers
// header and hit parsing, the majority vote, both search directions, the
// bottom DAC stop, start value selection with calibration mode writes,
// error reporting, restarts, random input gaps and result back-pressure.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Behavioral constants of the search, kept separate from the package
  localparam int          N_TRIALS     = 20;
  localparam logic [15:0] HDR_MASK     = 16'h8ffc;
  localparam logic [15:0] HDR_MATCH    = 16'h87f8;
  localparam logic [7:0]  DAC_TOP      = 8'd253;
  localparam logic [7:0]  CAL_LEVEL    = 8'd250;
  localparam logic [7:0]  START_ROW    = 8'd100;
  localparam logic [7:0]  START_ZERO   = 8'd20;
  localparam logic [7:0]  LEVEL_AT_RST = 8'd9;

  localparam int RANDOM_ITEMS = 850;
  localparam int HOLD_CYCLES  = 400;
  localparam int SETTLE       = 4;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int CYCLE_LIMIT  = 1000000;

  typedef struct packed {
    pts_pkg::kind_e kind;
    logic [7:0]     value;
  } scan_reply_t;

  // Clock, reset and ports
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        cfg_we_i      = 1'b0;
  logic        cfg_wdata_i   = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata  = '0;
  logic [1:0]  s_axis_tuser  = pts_pkg::FuncNone;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // Predictor state
  bit              cal_mode;
  logic [7:0]      lvl_last;
  logic [7:0]      dac;
  pts_pkg::phase_e phase;
  logic [4:0]      ev_cnt;
  logic [4:0]      fired_cnt;
  bit              ev_open;
  bit              ev_hit;
  bit              hdr_bad;

  scan_reply_t scan_replies[$];
  scan_reply_t exp_reply;

  // Stream control and statistics
  bit          tx_idle_en  = 1'b1;
  bit          rx_stall_en = 1'b0;
  bit          hold_tog    = 1'b0;
  bit          hold_seen   = 1'b0;
  int          hold_left   = 0;
  int          stall_left  = 0;
  int          cycle_cnt   = 0;
  int          items_sent  = 0;
  int          replies_ok  = 0;
  int          levels_found = 0;
  int          searches_aborted = 0;
  int          cal_writes  = 0;
  int          mismatches  = 0;

  pixel_threshold_scan u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("cycle limit reached with %0d results outstanding", scan_replies.size());
      $display("testbench: errors");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Random helpers
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else if (r < 97) return $urandom_range(4, 12);
    else return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] rnd16();
    return 16'($urandom);
  endfunction

  function automatic bit rbit();
    return 1'($urandom);
  endfunction

  function automatic logic [15:0] hdr_word();
    return HDR_MATCH | (rnd16() & ~HDR_MASK);
  endfunction

  function automatic logic [15:0] hit_word();
    return rnd16() & 16'h7fff;
  endfunction

  // A word failing the header test; bit 15 may be clear only at burst start
  function automatic logic [15:0] bad_header(input bit any_msb);
    logic [15:0] w;
    do begin
      w = rnd16();
      if (!any_msb) w[15] = 1'b1;
    end while ((w & HDR_MASK) == HDR_MATCH);
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  task automatic scan_reset();
    cal_mode = 1'b0;
    lvl_last = LEVEL_AT_RST;
    dac      = 8'd0;
    phase    = pts_pkg::PhIdle;
    burst_clear();
  endtask

  task automatic burst_clear();
    ev_cnt    = '0;
    fired_cnt = '0;
    ev_open   = 1'b0;
    ev_hit    = 1'b0;
    hdr_bad   = 1'b0;
  endtask

  task automatic event_close();
    if (ev_open && ev_hit) fired_cnt++;
    ev_open = 1'b0;
    ev_hit  = 1'b0;
  endtask

  task automatic push_reply(input pts_pkg::kind_e k, input logic [7:0] v);
    scan_reply_t r;
    r.kind  = k;
    r.value = v;
    scan_replies.insert(scan_replies.size(), r);
  endtask

  task automatic parse_word(input logic [15:0] w);
    if (!hdr_bad) begin
      if (ev_open && !w[15]) begin
        ev_hit = 1'b1;
      end else begin
        if (ev_open) event_close();
        // Drop everything once the last event has been taken and closed
        if (ev_cnt < 5'(N_TRIALS)) begin
          if ((w & HDR_MASK) != HDR_MATCH) begin
            hdr_bad = 1'b1;
          end else begin
            ev_cnt++;
            ev_open = 1'b1;
            ev_hit  = 1'b0;
          end
        end
      end
    end
  endtask

  task automatic burst_end();
    bit             voted;
    bit             has_err;
    pts_pkg::kind_e err;
    logic [7:0]     level;
    event_close();
    has_err = 1'b1;
    err     = pts_pkg::KindMissing;
    if (hdr_bad) err = pts_pkg::KindWrong;
    else if (ev_cnt >= 5'(N_TRIALS)) has_err = 1'b0;
    voted = fired_cnt > 5'(N_TRIALS / 2);
    burst_clear();
    if (phase != pts_pkg::PhIdle) begin
      if (has_err) begin
        phase = pts_pkg::PhIdle;
        searches_aborted++;
        push_reply(err, 8'd0);
      end else if (phase == pts_pkg::PhFirst) begin
        if (voted) begin
          dac   = dac - 8'd1;
          phase = pts_pkg::PhDown;
        end else begin
          dac   = dac + 8'd1;
          phase = pts_pkg::PhUp;
        end
        push_reply(pts_pkg::KindSetDac, dac);
      end else if (phase == pts_pkg::PhDown && voted && dac > 8'd0) begin
        dac = dac - 8'd1;
        push_reply(pts_pkg::KindSetDac, dac);
      end else if (phase == pts_pkg::PhUp && !voted && dac < DAC_TOP) begin
        dac = dac + 8'd1;
        push_reply(pts_pkg::KindSetDac, dac);
      end else begin
        level = (phase == pts_pkg::PhDown) ? dac + 8'd1 : dac;
        lvl_last = level;
        phase    = pts_pkg::PhIdle;
        levels_found++;
        push_reply(pts_pkg::KindFound, level);
      end
    end
  endtask

  task automatic scan_step(input pts_pkg::func_e f, input bit row, input logic [15:0] w);
    logic [7:0] start_val;
    case (f)
      pts_pkg::FuncStart: begin
        start_val = lvl_last;
        if (row || (lvl_last > CAL_LEVEL && cal_mode)) start_val = START_ROW;
        if (start_val == 8'd0) start_val = START_ZERO;
        burst_clear();
        dac   = start_val;
        phase = pts_pkg::PhFirst;
        push_reply(pts_pkg::KindSetDac, dac);
      end
      pts_pkg::FuncWord: parse_word(w);
      pts_pkg::FuncEnd:  burst_end();
      default: ;
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Result side: ready generation and checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Drop ready for random stalls, or for a long hold when requested
  always @(posedge clk_i) begin
    if (hold_tog != hold_seen) begin
      hold_seen = hold_tog;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (rx_stall_en && $urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
      m_axis_tready <= (stall_left == 0);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (scan_replies.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d value %0d",
                                  m_axis_tuser, m_axis_tdata));
      end else begin
        exp_reply = scan_replies.pop_front();
        if (m_axis_tuser !== exp_reply.kind)
          report_mismatch($sformatf("kind %0d, predicted %0d",
                                    m_axis_tuser, exp_reply.kind));
        if (m_axis_tdata !== exp_reply.value)
          report_mismatch($sformatf("value %0d, predicted %0d (kind %0d)",
                                    m_axis_tdata, exp_reply.value, exp_reply.kind));
        replies_ok++;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Input side
  // --------------------------------------------------------------------------
  // Offer one transaction and hold it until accepted; valid stays high after
  task automatic send_item(input pts_pkg::func_e f, input bit row, input logic [15:0] w);
    int gap;
    gap = tx_idle_en ? pick_gap() : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {7'd0, w, row};
    do @(posedge clk_i); while (!s_axis_tready);
    scan_step(f, row, w);
    if (f != pts_pkg::FuncNone) items_sent++;
  endtask

  // Stop offering, wait for every predicted result, then let the pipe settle
  task automatic drain();
    int waited;
    waited = 0;
    s_axis_tvalid <= 1'b0;
    while (scan_replies.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (scan_replies.size() != 0) begin
      report_mismatch($sformatf("%0d predicted results never arrived",
                                scan_replies.size()));
      scan_replies.delete();
    end
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_cal(input bit v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cal_mode = v;
    cal_writes++;
    cfg_we_i    <= 1'b0;
  endtask

  // One readout burst: headers, hits on n_fire events, optional bad header
  // at event bad_at, junk words after the last event, then end of burst
  task automatic send_burst(input int n_ev, input int n_fire, input int hits_max,
                            input int bad_at, input int junk);
    int fires_left;
    int nh;
    bit fire;
    fires_left = n_fire;
    for (int i = 0; i < n_ev; i++) begin
      if (i == bad_at) send_item(pts_pkg::FuncWord, rbit(), bad_header(i == 0));
      else send_item(pts_pkg::FuncWord, rbit(), hdr_word());
      fire = fires_left > 0 && $urandom_range(1, n_ev - i) <= fires_left;
      if (fire) fires_left--;
      nh = fire ? $urandom_range(1, hits_max) : 0;
      repeat (nh) send_item(pts_pkg::FuncWord, rbit(), hit_word());
    end
    repeat (junk) send_item(pts_pkg::FuncWord, rbit(), rnd16());
    send_item(pts_pkg::FuncEnd, rbit(), rnd16());
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Idle and unused functions, errors, latched header error, restart
  task automatic test_directed_cases();
    tx_idle_en  = 1'b1;
    rx_stall_en <= 1'b1;
    send_item(pts_pkg::FuncEnd, 1'b1, 16'hffff);
    send_item(pts_pkg::FuncNone, 1'b1, 16'hffff);
    send_item(pts_pkg::FuncNone, 1'b0, 16'h0000);
    // First pixel after reset starts from the reset level
    send_item(pts_pkg::FuncStart, 1'b0, 16'h0000);
    send_item(pts_pkg::FuncEnd, 1'b0, 16'h0000);
    // First row forces the default start; a hit word at burst start is bad
    send_item(pts_pkg::FuncStart, 1'b1, 16'hffff);
    send_item(pts_pkg::FuncWord, 1'b0, 16'h1234);
    send_item(pts_pkg::FuncWord, 1'b1, 16'h87f8);
    send_item(pts_pkg::FuncEnd, 1'b1, 16'hffff);
    // Extreme headers and hits, then a bad header latched mid burst
    send_item(pts_pkg::FuncStart, 1'b0, 16'hffff);
    send_item(pts_pkg::FuncWord, 1'b1, 16'h87f8);
    send_item(pts_pkg::FuncWord, 1'b0, 16'h0000);
    send_item(pts_pkg::FuncWord, 1'b0, 16'hf7fb);
    send_item(pts_pkg::FuncWord, 1'b1, 16'h7fff);
    send_item(pts_pkg::FuncWord, 1'b0, 16'hffff);
    send_item(pts_pkg::FuncWord, 1'b1, 16'h87f8);
    send_item(pts_pkg::FuncEnd, 1'b0, 16'h0000);
    // Restart in the middle of a burst clears the parser
    send_item(pts_pkg::FuncStart, 1'b0, 16'h0000);
    send_item(pts_pkg::FuncWord, 1'b1, 16'h87f8);
    send_item(pts_pkg::FuncStart, 1'b1, 16'h0000);
    send_item(pts_pkg::FuncEnd, 1'b0, 16'h0000);
    drain();
  endtask

  // Majority vote at its boundary; junk words after the last event may hit it
  task automatic test_vote_boundary();
    send_item(pts_pkg::FuncStart, 1'b1, rnd16());
    send_burst(N_TRIALS, N_TRIALS / 2 + 1, 1, -1, 0);
    send_burst(N_TRIALS, N_TRIALS / 2, 3, -1, 0);
    send_item(pts_pkg::FuncStart, 1'b1, rnd16());
    send_burst(N_TRIALS, N_TRIALS / 2, 2, -1, 6);
    send_burst(N_TRIALS, N_TRIALS, 1, -1, 3);
    send_burst(N_TRIALS - 1, 0, 1, -1, 0);
    drain();
  endtask

  // Step the DAC down from the reset level to its bottom stop, then short
  // searches from the low level found, with and without calibration mode
  task automatic test_dac_limits();
    tx_idle_en  = 1'b0;
    rx_stall_en <= 1'b0;
    write_cal(1'b0);
    send_item(pts_pkg::FuncStart, 1'b0, rnd16());
    while (phase != pts_pkg::PhIdle) send_burst(N_TRIALS, N_TRIALS, 1, -1, 0);
    // A low level steps up once and stops on a fire
    send_item(pts_pkg::FuncStart, 1'b0, rnd16());
    send_burst(N_TRIALS, 0, 1, -1, 0);
    send_burst(N_TRIALS, N_TRIALS, 2, -1, 0);
    // Calibration mode leaves a low last level as the start
    write_cal(1'b1);
    send_item(pts_pkg::FuncStart, 1'b0, rnd16());
    send_burst(N_TRIALS, 3, 1, -1, 0);
    send_burst(N_TRIALS, 15, 1, -1, 0);
    drain();
  endtask

  // Long receiver hold while results pile up and stall the input
  task automatic test_backpressure();
    tx_idle_en  = 1'b0;
    rx_stall_en <= 1'b0;
    hold_tog <= ~hold_tog;
    repeat (12) begin
      send_item(pts_pkg::FuncStart, rbit(), rnd16());
      send_item(pts_pkg::FuncWord, rbit(), hdr_word());
      send_item(pts_pkg::FuncEnd, rbit(), rnd16());
    end
    drain();
    tx_idle_en = 1'b1;
    hold_tog <= ~hold_tog;
    send_item(pts_pkg::FuncStart, 1'b1, rnd16());
    repeat (4) send_burst(N_TRIALS, $urandom_range(8, 13), 2, -1, 0);
    drain();
  endtask

  // Mostly well-formed searches with random content, some noise
  task automatic test_random_scans();
    int base;
    int r;
    int n_ev;
    int bad_at;
    int n_fire;
    base = items_sent;
    while (items_sent - base < RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      tx_idle_en  = $urandom_range(0, 9) < 7;
      rx_stall_en <= $urandom_range(0, 9) < 7;
      if (r < 80) begin
        send_item(pts_pkg::FuncStart, $urandom_range(0, 2) == 0, rnd16());
        repeat ($urandom_range(1, 8)) begin
          n_ev   = N_TRIALS;
          bad_at = -1;
          r = $urandom_range(0, 99);
          if (r < 7) bad_at = $urandom_range(0, N_TRIALS - 1);
          else if (r < 13) n_ev = $urandom_range(0, N_TRIALS - 1);
          n_fire = $urandom_range(0, 1) ? $urandom_range(0, N_TRIALS)
                                         : $urandom_range(9, 12);
          send_burst(n_ev, n_fire, $urandom_range(1, 3), bad_at,
                     $urandom_range(0, 4) == 0 ? $urandom_range(1, 4) : 0);
        end
      end else if (r < 93) begin
        repeat ($urandom_range(1, 6))
          send_item(pts_pkg::func_e'($urandom_range(0, 3)), rbit(), rnd16());
      end else begin
        write_cal(rbit());
      end
    end
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    scan_reset();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_dac_limits();
    test_vote_boundary();
    test_backpressure();
    test_random_scans();
    drain();
    $display("run covered %0d input transactions, %0d results checked, %0d mode writes",
             items_sent, replies_ok, cal_writes);
    $display("searches ended with %0d levels found and %0d aborted, %0d mismatches",
             levels_found, searches_aborted, mismatches);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
